// File: sv/bcpfsk_pkg.sv
// Shared constants, types and the sine/cosine table builder for the CPFSK modulator.
package bcpfsk_pkg;

   localparam int MAX_SPS_DEFAULT   = 64;
   localparam int SINE_BITS_DEFAULT = 10;

   localparam int PHASE_W   = 32;
   localparam int AMP_W     = 15;
   localparam int SPS_W     = 7;
   localparam int SYMBOL_W  = 8;
   localparam int SAMPLE_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int TRIG_W    = 32;
   localparam int PROD_W    = 48;

   localparam logic [SPS_W-1:0]    SPS_RESET = 7'd2;
   localparam logic [AMP_W-1:0]    AMP_RESET = 15'd32767;
   localparam logic [SYMBOL_W-1:0] SYMBOL_UP = 8'd1;

   // Rounding half of a Q1.30 product before the floor shift
   localparam logic signed [PROD_W-1:0] ROUND_Q30 = 48'sd536870912;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP         = 2'd0,
      CSR_AMPLITUDE          = 2'd1,
      CSR_SAMPLES_PER_SYMBOL = 2'd2
   } csr_index_type;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam int    CORDIC_STEPS = 24;
   localparam longint CORDIC_X0   = 64'sd652032874;
   localparam longint ONE_Q30     = 64'sd1073741824;

   localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   typedef struct packed {
      logic [TRIG_W-1:0] cos_q30;
      logic [TRIG_W-1:0] sin_q30;
   } trig_pair_type;

   // Elaboration-time CORDIC for one first-quadrant table entry, clamped to +/-1.0
   function automatic trig_pair_type cordic_entry(int res_idx, int table_bits);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      trig_pair_type entry;
      x = CORDIC_X0;
      y = 0;
      z = longint'(res_idx) <<< (32 - table_bits);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURNS[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURNS[i];
         end
      end
      if (x > ONE_Q30) x = ONE_Q30;
      if (x < -ONE_Q30) x = -ONE_Q30;
      if (y > ONE_Q30) y = ONE_Q30;
      if (y < -ONE_Q30) y = -ONE_Q30;
      entry.cos_q30 = x[TRIG_W-1:0];
      entry.sin_q30 = y[TRIG_W-1:0];
      return entry;
   endfunction

endpackage

// File: sv/binary_cpfsk_modulator_core.sv
// Binary continuous-phase FSK modulator: symbol sequencer, phase accumulator, sample pipeline.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------------------
//   req     | in        | req_valid / req_ready | req_symbol[7:0]
//   rsp     | out       | rsp_valid / rsp_ready | rsp_i_sample, rsp_q_sample, rsp_last_sample
//   csr     | in        | csr_wr_en             | csr_index[1:0], csr_wdata[31:0]
//
// Each symbol transaction yields N sample transactions, N = samples_per_symbol clamped to
// 1..MAX_SAMPLES_PER_SYMBOL (N is 2 at reset), one per cycle while rsp is not stalled; the
// phase accumulator steps once per sample issued.
// After accept, a symbol's samples pass through the phase, table, multiply and output registers.
// Synchronous active-high reset clears phase to zero, all pipeline valids, and loads
// register defaults (phase_step 0, amplitude 32767, samples_per_symbol 2).
// A stalled rsp freezes the whole pipeline; a new symbol is still taken while the last
// sample of the previous one waits in the output register.
module binary_cpfsk_modulator_core #(
   parameter int MAX_SAMPLES_PER_SYMBOL = bcpfsk_pkg::MAX_SPS_DEFAULT,
   parameter int SINE_TABLE_BITS        = bcpfsk_pkg::SINE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // symbol input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bcpfsk_pkg::SYMBOL_W-1:0]       req_symbol,
   // sample output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bcpfsk_pkg::SAMPLE_W-1:0] rsp_i_sample,
   output logic signed [bcpfsk_pkg::SAMPLE_W-1:0] rsp_q_sample,
   output logic                                  rsp_last_sample,
   // configuration writes
   input  logic                                  csr_wr_en,
   input  logic [bcpfsk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bcpfsk_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PW       = bcpfsk_pkg::PHASE_W;
   localparam int SW       = bcpfsk_pkg::SAMPLE_W;
   localparam int TW       = bcpfsk_pkg::TRIG_W;
   localparam int AW       = bcpfsk_pkg::AMP_W;
   localparam int NW       = bcpfsk_pkg::SPS_W;
   localparam int PRW      = bcpfsk_pkg::PROD_W;
   localparam int CNT_W    = (MAX_SAMPLES_PER_SYMBOL > 1) ? $clog2(MAX_SAMPLES_PER_SYMBOL) : 1;
   localparam int RES_BITS = SINE_TABLE_BITS - 2;
   localparam int RES_DEPTH = 1 << RES_BITS;
   localparam logic [NW-1:0] MAX_SPS = NW'(MAX_SAMPLES_PER_SYMBOL);

   // ---------------------------------------------------------------- configuration
   logic [PW-1:0] phase_step_ff, phase_step_in;
   logic [AW-1:0] amplitude_ff,  amplitude_in;
   logic [NW-1:0] sps_ff,        sps_in;

   always_comb begin
      phase_step_in = phase_step_ff;
      amplitude_in  = amplitude_ff;
      sps_in        = sps_ff;
      if (csr_wr_en) begin
         case (bcpfsk_pkg::csr_index_type'(csr_index))
            bcpfsk_pkg::CSR_PHASE_STEP:         phase_step_in = csr_wdata[PW-1:0];
            bcpfsk_pkg::CSR_AMPLITUDE:          amplitude_in  = csr_wdata[AW-1:0];
            bcpfsk_pkg::CSR_SAMPLES_PER_SYMBOL: sps_in        = csr_wdata[NW-1:0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         amplitude_ff  <= bcpfsk_pkg::AMP_RESET;
         sps_ff        <= bcpfsk_pkg::SPS_RESET;
      end else begin
         phase_step_ff <= phase_step_in;
         amplitude_ff  <= amplitude_in;
         sps_ff        <= sps_in;
      end
   end

   // Clamp samples per symbol into 1..MAX and turn it into a down-count start value
   logic [NW-1:0]    sps_clamped;
   logic [CNT_W-1:0] sps_last_idx;

   always_comb begin
      if (sps_ff == '0) begin
         sps_clamped = NW'(1);
      end else if (sps_ff > MAX_SPS) begin
         sps_clamped = MAX_SPS;
      end else begin
         sps_clamped = sps_ff;
      end
      sps_last_idx = CNT_W'(sps_clamped - NW'(1));
   end

   // ---------------------------------------------------------------- pipeline advance
   // Every stage moves together whenever the output register is free or being drained.
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;

   assign advance = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------- symbol sequencer
   logic             sym_valid_ff, sym_valid_in;
   logic             up_ff,        up_in;
   logic [CNT_W-1:0] cnt_ff,       cnt_in;
   logic [PW-1:0]    phase_ff,     phase_in;
   logic [PW-1:0]    phase_next;
   logic             issue;
   logic             sym_last;
   logic             req_accept;

   assign issue      = sym_valid_ff && advance;
   assign sym_last   = (cnt_ff == '0);
   assign req_ready  = !sym_valid_ff || (issue && sym_last);
   assign req_accept = req_valid && req_ready;
   assign phase_next = up_ff ? (phase_ff + phase_step_ff) : (phase_ff - phase_step_ff);

   always_comb begin
      sym_valid_in = sym_valid_ff;
      up_in        = up_ff;
      cnt_in       = cnt_ff;
      phase_in     = issue ? phase_next : phase_ff;
      if (req_accept) begin
         // load a new symbol; this also covers the cycle its predecessor finishes
         sym_valid_in = 1'b1;
         up_in        = (req_symbol == bcpfsk_pkg::SYMBOL_UP);
         cnt_in       = sps_last_idx;
      end else if (issue) begin
         if (sym_last) begin
            sym_valid_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_valid_ff <= 1'b0;
         phase_ff     <= '0;
      end else begin
         sym_valid_ff <= sym_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff  <= up_in;
      cnt_ff <= cnt_in;
   end

   // ---------------------------------------------------------------- stage 1: phase index
   logic                       s1_valid_ff, s1_valid_in;
   logic [SINE_TABLE_BITS-1:0] s1_index_ff, s1_index_in;
   logic                       s1_last_ff,  s1_last_in;

   assign s1_valid_in = advance ? issue : s1_valid_ff;
   assign s1_index_in = advance ? phase_next[PW-1 -: SINE_TABLE_BITS] : s1_index_ff;
   assign s1_last_in  = advance ? sym_last : s1_last_ff;

   // ---------------------------------------------------------------- stage 2: table lookup
   // First-quadrant cos/sin table in Q1.30, built at elaboration.
   logic [TW-1:0] tab_cos [RES_DEPTH];
   logic [TW-1:0] tab_sin [RES_DEPTH];

   for (genvar j = 0; j < RES_DEPTH; j++) begin : g_tab
      localparam bcpfsk_pkg::trig_pair_type ENTRY =
         bcpfsk_pkg::cordic_entry(j, SINE_TABLE_BITS);
      assign tab_cos[j] = ENTRY.cos_q30;
      assign tab_sin[j] = ENTRY.sin_q30;
   end

   logic          s2_valid_ff, s2_valid_in;
   logic [TW-1:0] s2_cos_ff,   s2_cos_in;
   logic [TW-1:0] s2_sin_ff,   s2_sin_in;
   logic [1:0]    s2_quad_ff,  s2_quad_in;
   logic          s2_last_ff,  s2_last_in;

   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
   assign s2_cos_in   = advance ? tab_cos[s1_index_ff[RES_BITS-1:0]] : s2_cos_ff;
   assign s2_sin_in   = advance ? tab_sin[s1_index_ff[RES_BITS-1:0]] : s2_sin_ff;
   assign s2_quad_in  = advance ? s1_index_ff[SINE_TABLE_BITS-1 -: 2] : s2_quad_ff;
   assign s2_last_in  = advance ? s1_last_ff : s2_last_ff;

   // ---------------------------------------------------------------- stage 3: amplitude scale
   logic signed [PRW-1:0] prod_cos;
   logic signed [PRW-1:0] prod_sin;
   logic signed [PRW-1:0] rnd_cos;
   logic signed [PRW-1:0] rnd_sin;

   assign prod_cos = PRW'($signed({1'b0, amplitude_ff})) * PRW'($signed(s2_cos_ff));
   assign prod_sin = PRW'($signed({1'b0, amplitude_ff})) * PRW'($signed(s2_sin_ff));
   assign rnd_cos  = prod_cos + bcpfsk_pkg::ROUND_Q30;
   assign rnd_sin  = prod_sin + bcpfsk_pkg::ROUND_Q30;

   logic          s3_valid_ff, s3_valid_in;
   logic [SW-1:0] s3_cos_ff,   s3_cos_in;
   logic [SW-1:0] s3_sin_ff,   s3_sin_in;
   logic [1:0]    s3_quad_ff,  s3_quad_in;
   logic          s3_last_ff,  s3_last_in;

   // Floor shift by 30 then keep the low 16 bits
   assign s3_valid_in = advance ? s2_valid_ff : s3_valid_ff;
   assign s3_cos_in   = advance ? rnd_cos[30 +: SW] : s3_cos_ff;
   assign s3_sin_in   = advance ? rnd_sin[30 +: SW] : s3_sin_ff;
   assign s3_quad_in  = advance ? s2_quad_ff : s3_quad_ff;
   assign s3_last_in  = advance ? s2_last_ff : s3_last_ff;

   // ---------------------------------------------------------------- output: quadrant fold
   logic [SW-1:0] fold_i;
   logic [SW-1:0] fold_q;

   always_comb begin
      case (s3_quad_ff)
         bcpfsk_pkg::QUAD_0: begin
            fold_i = s3_cos_ff;
            fold_q = s3_sin_ff;
         end
         bcpfsk_pkg::QUAD_1: begin
            fold_i = -s3_sin_ff;
            fold_q = s3_cos_ff;
         end
         bcpfsk_pkg::QUAD_2: begin
            fold_i = -s3_cos_ff;
            fold_q = -s3_sin_ff;
         end
         default: begin
            fold_i = s3_sin_ff;
            fold_q = -s3_cos_ff;
         end
      endcase
   end

   logic [SW-1:0] rsp_i_ff,    rsp_i_in;
   logic [SW-1:0] rsp_q_ff,    rsp_q_in;
   logic          rsp_last_ff, rsp_last_in;

   assign rsp_valid_in = advance ? s3_valid_ff : rsp_valid_ff;
   assign rsp_i_in     = advance ? fold_i : rsp_i_ff;
   assign rsp_q_in     = advance ? fold_q : rsp_q_ff;
   assign rsp_last_in  = advance ? s3_last_ff : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff <= s1_index_in;
      s1_last_ff  <= s1_last_in;
      s2_cos_ff   <= s2_cos_in;
      s2_sin_ff   <= s2_sin_in;
      s2_quad_ff  <= s2_quad_in;
      s2_last_ff  <= s2_last_in;
      s3_cos_ff   <= s3_cos_in;
      s3_sin_ff   <= s3_sin_in;
      s3_quad_ff  <= s3_quad_in;
      s3_last_ff  <= s3_last_in;
      rsp_i_ff    <= rsp_i_in;
      rsp_q_ff    <= rsp_q_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_i_sample    = $signed(rsp_i_ff);
   assign rsp_q_sample    = $signed(rsp_q_ff);
   assign rsp_last_sample = rsp_last_ff;

endmodule

// File: sv/bcpfsk_checker.sv
// Port-level checker for the CPFSK modulator, bound to the top level.
module bcpfsk_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [bcpfsk_pkg::SAMPLE_W-1:0] rsp_i_sample,
   input logic signed [bcpfsk_pkg::SAMPLE_W-1:0] rsp_q_sample,
   input logic                                   rsp_last_sample
);

   localparam logic [bcpfsk_pkg::SAMPLE_W-1:0] MOST_NEGATIVE = 16'h8000;

   // Reset empties the pipeline and opens the symbol input
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

   // A held sample transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_i_sample) && $stable(rsp_q_sample)
          && $stable(rsp_last_sample)))
      else $error("stalled sample changed or dropped");

   // Samples of one symbol leave without gaps
   a_symbol_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_sample) |=> rsp_valid)
      else $error("gap inside a symbol's sample burst");

   // Amplitude is at most 32767, so no sample reaches the most negative code
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_i_sample != MOST_NEGATIVE) && (rsp_q_sample != MOST_NEGATIVE)))
      else $error("sample out of amplitude range");

endmodule

bind binary_cpfsk_modulator_core bcpfsk_checker u_bcpfsk_checker (.*);
